[rtl/sbsp_pkg.sv]
// shared types and constants of the soft brush stamp painter
package sbsp_pkg;

	localparam int MaxWidth   = 64;
	localparam int MaxHeight  = 64;
	localparam int MaxRadius  = 63;
	localparam int ColBits    = $clog2(MaxWidth);
	localparam int RowBits    = $clog2(MaxHeight);
	localparam int AddrBits   = ColBits + RowBits;
	localparam int Depth      = MaxWidth * MaxHeight;
	localparam int PixBits    = 32;
	localparam int CntBits    = 14;
	localparam int BlendLevel = 128;

	localparam logic [1:0] OP_PAINT = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_FILL  = 2'd3;

	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	// request from the sequencer to the shading unit
	typedef struct packed {
		logic        start;
		logic [12:0] d2;
		logic [11:0] rr;
	} shade_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] alpha;
	} shade_rsp_t;

endpackage

[rtl/soft_brush_stamp_painter.sv]
// soft brush stamp painter: sequencer, image RAM and falloff unit
// paint walks the 2r square pixel by pixel; each painted pixel goes through the falloff unit,
// whose 32-step divider is skipped in the flat core, then a read and a write of the RAM
// one transaction in flight; s_tready is low from acceptance until the result is taken
// reset clears control state and sets width and height to 64; the image RAM is not cleared
module soft_brush_stamp_painter import sbsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[1:0], x_pos[13:2], y_pos[25:14], red, green, blue, alpha_val, radius[63:58]
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_red, read_green, read_blue, read_alpha, pixels_written[45:32], status[46]
	output logic [47:0] m_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	localparam logic [2:0] P_IDLE = 3'd0, P_PIX = 3'd1, P_SHADE = 3'd2, P_RD = 3'd3,
		P_WR = 3'd4, P_RESP = 3'd5, P_FILL = 3'd6, P_RDW = 3'd7;

	logic [2:0]  state_q;
	logic [6:0]  width_q, height_q;
	logic [1:0]  op_q;
	logic signed [12:0] cx_q, cy_q, x_q, y_q;
	logic [7:0]  r_q, g_q, b_q, a_q;
	logic [5:0]  rad_q;
	logic [CntBits-1:0] cnt_q;
	logic        status_q;
	logic [31:0] rd_q;
	logic [16:0] alpha_q;
	logic [6:0]  w_eff, h_eff;

	logic                we;
	logic [AddrBits-1:0] addr;
	logic [31:0]         wdata, rdata;
	shade_req_t          sreq;
	shade_rsp_t          srsp;

	assign w_eff = (width_q > 7'(MaxWidth)) ? 7'(MaxWidth) : width_q;
	assign h_eff = (height_q > 7'(MaxHeight)) ? 7'(MaxHeight) : height_q;

	logic signed [12:0] req_x, req_y;
	assign req_x = $signed({s_tdata[13], s_tdata[13:2]});
	assign req_y = $signed({s_tdata[25], s_tdata[25:14]});

	logic signed [12:0] dx, dy;
	logic [12:0] d2;
	logic [11:0] rr;
	logic in_img, in_sq_end_x, in_sq_end_y;
	assign dx = x_q - cx_q;
	assign dy = y_q - cy_q;
	assign d2 = 13'(dx * dx) + 13'(dy * dy);
	assign rr = 12'(rad_q * rad_q);
	assign in_img = !x_q[12] && !y_q[12] && (x_q < $signed({6'd0, w_eff}))
		&& (y_q < $signed({6'd0, h_eff}));
	assign in_sq_end_x = (x_q + 13'sd1 >= cx_q + $signed({7'd0, rad_q}));
	assign in_sq_end_y = (y_q + 13'sd1 >= cy_q + $signed({7'd0, rad_q}));
	assign addr = {y_q[RowBits-1:0], x_q[ColBits-1:0]};

	// channel scaling for the paint write, with a per-channel max against the old pixel when red exceeds BlendLevel
	logic [7:0] nr, ng, nb;
	logic [23:0] pr, pg, pb;
	always_comb begin
		pr = {7'd0, alpha_q} * {16'd0, r_q};
		pg = {7'd0, alpha_q} * {16'd0, g_q};
		pb = {7'd0, alpha_q} * {16'd0, b_q};
		nr = pr[23:16];
		ng = pg[23:16];
		nb = pb[23:16];
		if (r_q > 8'(BlendLevel)) begin
			if (rdata[7:0] > nr) nr = rdata[7:0];
			if (rdata[15:8] > ng) ng = rdata[15:8];
			if (rdata[23:16] > nb) nb = rdata[23:16];
		end
	end

	always_comb begin
		we = 1'b0;
		wdata = {a_q, b_q, g_q, r_q};
		if (state_q == P_FILL) we = 1'b1;
		if (state_q == P_WR) begin
			// painted pixels are always in the image; a pixel write may not be
			we = in_img;
			if (op_q == OP_PAINT) wdata = {a_q, nb, ng, nr};
		end
	end

	assign sreq.start = (state_q == P_PIX) && in_img && (d2 <= {1'b0, rr});
	assign sreq.d2 = d2;
	assign sreq.rr = rr;

	sbsp_ram #(.Width(PixBits), .Depth(Depth)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	sbsp_shade u_shade (.clk(clk), .arst_n(arst_n), .req(sreq), .rsp(srsp));

	assign s_tready = (state_q == P_IDLE);
	assign m_tvalid = (state_q == P_RESP);
	assign m_tdata = {1'b0, status_q, cnt_q, rd_q};

	// advance the walk over the square; last pixel finishes the transaction
	logic signed [12:0] x_start;
	assign x_start = cx_q - $signed({7'd0, rad_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			width_q <= 7'd64;
			height_q <= 7'd64;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:  width_q <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				P_IDLE: if (s_tvalid) begin
					op_q <= s_tdata[1:0];
					cx_q <= req_x;
					cy_q <= req_y;
					r_q <= s_tdata[33:26];
					g_q <= s_tdata[41:34];
					b_q <= s_tdata[49:42];
					a_q <= s_tdata[57:50];
					rad_q <= s_tdata[63:58];
					cnt_q <= '0;
					status_q <= 1'b0;
					rd_q <= '0;
					unique case (s_tdata[1:0])
						OP_PAINT: begin
							x_q <= req_x - $signed({7'd0, s_tdata[63:58]});
							y_q <= req_y - $signed({7'd0, s_tdata[63:58]});
							state_q <= (s_tdata[63:58] == 6'd0) ? P_RESP : P_PIX;
						end
						OP_WRITE: begin
							x_q <= req_x;
							y_q <= req_y;
							state_q <= P_WR;
						end
						OP_READ: begin
							x_q <= req_x;
							y_q <= req_y;
							state_q <= P_RD;
						end
						default: begin
							x_q <= '0;
							y_q <= '0;
							state_q <= (w_eff == 7'd0 || h_eff == 7'd0) ? P_RESP : P_FILL;
						end
					endcase
				end
				P_PIX: begin
					if (sreq.start) begin
						state_q <= P_SHADE;
					end else if (in_sq_end_x && in_sq_end_y) begin
						state_q <= P_RESP;
					end else if (in_sq_end_x) begin
						x_q <= x_start;
						y_q <= y_q + 13'sd1;
					end else begin
						x_q <= x_q + 13'sd1;
					end
				end
				P_SHADE: if (srsp.done) begin
					alpha_q <= srsp.alpha;
					state_q <= P_RDW;
				end
				// read data arrives in the cycle after the read address
				P_RDW: begin
					if (op_q == OP_READ) begin
						rd_q <= rdata;
						state_q <= P_RESP;
					end else begin
						state_q <= P_WR;
					end
				end
				P_RD: begin
					if (!in_img) begin
						status_q <= 1'b1;
						state_q <= P_RESP;
					end else begin
						state_q <= P_RDW;
					end
				end
				P_WR: begin
					if (op_q == OP_WRITE) begin
						if (in_img) cnt_q <= 14'd1;
						else status_q <= 1'b1;
						state_q <= P_RESP;
					end else begin
						cnt_q <= cnt_q + 14'd1;
						if (in_sq_end_x && in_sq_end_y) begin
							state_q <= P_RESP;
						end else if (in_sq_end_x) begin
							x_q <= x_start;
							y_q <= y_q + 13'sd1;
							state_q <= P_PIX;
						end else begin
							x_q <= x_q + 13'sd1;
							state_q <= P_PIX;
						end
					end
				end
				P_FILL: begin
					cnt_q <= cnt_q + 14'd1;
					if (x_q + 13'sd1 >= $signed({6'd0, w_eff})) begin
						x_q <= '0;
						y_q <= y_q + 13'sd1;
						if (y_q + 13'sd1 >= $signed({6'd0, h_eff})) state_q <= P_RESP;
					end else begin
						x_q <= x_q + 13'sd1;
					end
				end
				P_RESP: begin
					if (m_tready) state_q <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end
endmodule

[rtl/sbsp_ram.sv]
// generic single-port RAM with registered read
module sbsp_ram #(
	parameter int Width = 32,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/sbsp_shade.sv]
// iterative brush falloff unit: restoring divide, then smoothstep on one shared multiplier
module sbsp_shade import sbsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  shade_req_t req,
	output shade_rsp_t rsp
);
	localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_SQ = 3'd2, S_CUB = 3'd3,
		S_OUT = 3'd4;

	logic [2:0]  state_q;
	logic [4:0]  cnt_q;
	logic [16:0] rem_q;
	logic [31:0] dvd_q;
	logic [16:0] quo_q;
	logic [15:0] den_q;
	logic [16:0] t_q;
	logic [33:0] prod_q;
	logic [17:0] shifted, diff;
	logic        qb;
	logic [15:0] num;
	logic [17:0] s_full;
	logic [17:0] mul_a, mul_b;
	logic [35:0] mul_p;

	// one restoring step: shift in the next dividend bit and try the subtract
	assign shifted = {rem_q, dvd_q[31]};
	assign diff = shifted - {2'd0, den_q};
	assign qb = !diff[17];
	assign num = 16'({req.d2, 4'd0} - {5'd0, req.rr});
	assign s_full = prod_q[33:16];

	always_comb begin
		mul_a = {1'b0, t_q};
		mul_b = {1'b0, t_q};
		if (state_q == S_CUB) begin
			mul_a = {1'b0, prod_q[32:16]};
			mul_b = 18'd196608 - {t_q, 1'b0};
		end
	end
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.start) begin
					if ({req.d2, 4'd0} <= {5'd0, req.rr}) begin
						// flat core of the brush: t is zero
						t_q <= '0;
						state_q <= S_SQ;
					end else begin
						// numerator shifted left by 16 and fed bitwise
						rem_q <= '0;
						quo_q <= '0;
						den_q <= {req.rr, 4'd0} - {4'd0, req.rr};
						dvd_q <= {num, 16'd0};
						cnt_q <= 5'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= qb ? diff[16:0] : shifted[16:0];
					quo_q <= {quo_q[15:0], qb};
					dvd_q <= {dvd_q[30:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						// quotient never exceeds 1.0, so 17 bits hold it
						t_q <= {quo_q[15:0], qb};
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					prod_q <= mul_p[33:0];
					state_q <= S_CUB;
				end
				S_CUB: begin
					prod_q <= mul_p[33:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					rsp.alpha <= (s_full > 18'd65536) ? 17'd0 : 17'(18'd65536 - s_full);
					rsp.done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
